// File: rtl/core/psched_pkg.sv
// psched_pkg: types, sizes and codes shared by the scheduler modules
// no dependencies; used by psched_ctrl, psched_dp and the top level

package psched_pkg;

    localparam int NUM_TASKS     = 3;
    localparam int NUM_SEMS      = 2;
    localparam int NUM_PRIO_REGS = 4;

    localparam int TASK_W    = 2;
    localparam int LINK_W    = 3;
    localparam int PRIO_W    = 7;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int TIDX_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int SIDX_W    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int STEP_W    = $clog2(NUM_TASKS + 1);

    localparam logic [LINK_W-1:0] NO_TASK    = 3'd7;
    localparam logic [PRIO_W-1:0] PRIO_LIMIT = 7'd100;

    localparam logic signed [CNT_W-1:0] CNT_MIN   = -4'sd8;
    localparam logic signed [CNT_W-1:0] CNT_MAX   = 4'sd7;
    localparam logic signed [CNT_W-1:0] CNT_RESET = 4'sd1;

    localparam logic [1:0] ST_READY  = 2'd0;
    localparam logic [1:0] ST_SLICED = 2'd1;
    localparam logic [1:0] ST_EXEC   = 2'd2;
    localparam logic [1:0] ST_WAIT   = 2'd3;

    localparam logic [1:0] KIND_SCHEDULE  = 2'd0;
    localparam logic [1:0] KIND_WAIT      = 2'd1;
    localparam logic [1:0] KIND_SIGNAL    = 2'd2;
    localparam logic [1:0] KIND_SLICE_END = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic       sem_index;
    } t_req;

    typedef struct packed {
        logic              running_valid;
        logic [TASK_W-1:0] running_task;
        logic              caller_blocked;
        logic              woken_valid;
        logic [TASK_W-1:0] woken_task;
        logic              no_runner_error;
    } t_res;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic exec;
        logic walk_step;
        logic result_load;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic need_walk;
        logic walk_done;
    } t_sts;

endpackage

// File: rtl/core/psched_ctrl.sv
// psched_ctrl: sequencing state machine of the scheduler
// depends on psched_pkg; drives psched_dp through t_cmd, reads t_sts

module psched_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [1:0]        i_req_kind,
    input  logic              i_res_stall,
    input  psched_pkg::t_sts  i_sts,
    output psched_pkg::t_cmd  o_cmd,
    output logic              o_req_stall,
    output logic              o_res_valid
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_res_valid;
    logic       n_res_valid;
    logic       req_acc;
    logic       res_free;

    assign req_acc  = i_req_valid && (r_state == S_IDLE);
    assign res_free = !r_res_valid || !i_res_stall;

    always_comb begin
        n_state     = r_state;
        n_res_valid = r_res_valid && i_res_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_req_kind == psched_pkg::KIND_SCHEDULE) ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_sts.need_walk ? S_WALK : S_FINISH;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (res_free) begin
                    o_cmd.result_load = 1'b1;
                    n_res_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;

endmodule

// File: rtl/core/psched_dp.sv
// psched_dp: task table, semaphores, priority scan, queue walk and result register
// depends on psched_pkg; commanded by psched_ctrl

module psched_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  psched_pkg::t_cmd                    i_cmd,
    input  psched_pkg::t_req                    i_req,
    input  logic                                i_cfg_we,
    input  logic [psched_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [psched_pkg::PRIO_W-1:0]       i_cfg_data,
    output psched_pkg::t_sts                    o_sts,
    output psched_pkg::t_res                    o_res
);

    localparam int NT = psched_pkg::NUM_TASKS;
    localparam int NS = psched_pkg::NUM_SEMS;
    localparam int TW = psched_pkg::TIDX_W;
    localparam int LW = psched_pkg::LINK_W;
    localparam int PW = psched_pkg::PRIO_W;
    localparam int CW = psched_pkg::CNT_W;

    logic [PW-1:0]        r_prio [psched_pkg::NUM_PRIO_REGS];
    logic [1:0]           r_tstate [NT];
    logic [LW-1:0]        r_link [NT];
    logic signed [CW-1:0] r_count [NS];
    logic [LW-1:0]        r_head [NS];
    logic [LW-1:0]        r_running;

    logic [1:0]                       r_kind;
    logic                             r_sem;
    logic [TW-1:0]                    r_scan_t;
    logic [PW-1:0]                    r_rdy_prio;
    logic [LW-1:0]                    r_rdy_idx;
    logic [PW-1:0]                    r_sld_prio;
    logic [LW-1:0]                    r_sld_idx;
    logic [LW-1:0]                    r_waiter;
    logic [LW-1:0]                    r_walk_t;
    logic [psched_pkg::STEP_W-1:0]    r_steps;
    logic                             r_blocked;
    logic                             r_woken_v;
    logic [LW-1:0]                    r_woken_t;
    logic                             r_err;
    psched_pkg::t_res                 r_res;

    logic                 has_runner;
    logic [TW-1:0]        run_idx;
    logic [PW-1:0]        run_prio;
    logic                 sem_ok;
    logic [psched_pkg::SIDX_W-1:0] sem_idx;
    logic signed [CW-1:0] cnt_dec;
    logic signed [CW-1:0] cnt_inc;
    logic [LW-1:0]        head;
    logic                 head_valid;
    logic [PW-1:0]        scan_prio;
    logic [LW-1:0]        pick_idx;
    logic [PW-1:0]        pick_prio;
    logic [TW-1:0]        walk_idx;
    logic [LW-1:0]        walk_link;
    logic                 walk_done;
    logic                 wait_blocks;

    assign has_runner = r_running < LW'(NT);
    assign run_idx    = r_running[TW-1:0];
    assign run_prio   = r_prio[2'(run_idx)];
    assign sem_ok     = 32'(r_sem) < NS;
    assign sem_idx    = psched_pkg::SIDX_W'(r_sem);
    assign cnt_dec    = (r_count[sem_idx] == psched_pkg::CNT_MIN) ?
                        r_count[sem_idx] : r_count[sem_idx] - CW'(1);
    assign cnt_inc    = (r_count[sem_idx] == psched_pkg::CNT_MAX) ?
                        r_count[sem_idx] : r_count[sem_idx] + CW'(1);
    assign head       = r_head[sem_idx];
    assign head_valid = head < LW'(NT);
    assign scan_prio  = r_prio[2'(r_scan_t)];
    assign pick_idx   = (r_rdy_idx != psched_pkg::NO_TASK) ? r_rdy_idx : r_sld_idx;
    assign pick_prio  = (r_rdy_idx != psched_pkg::NO_TASK) ? r_rdy_prio : r_sld_prio;
    assign walk_idx   = r_walk_t[TW-1:0];
    assign walk_link  = r_link[walk_idx];
    assign walk_done  = (r_steps == psched_pkg::STEP_W'(NT)) || (walk_link >= LW'(NT));
    assign wait_blocks = has_runner && sem_ok && (cnt_dec < 0);

    assign o_sts.scan_last = (r_scan_t == TW'(NT - 1));
    assign o_sts.need_walk = (r_kind == psched_pkg::KIND_WAIT) && wait_blocks && head_valid;
    assign o_sts.walk_done = walk_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < psched_pkg::NUM_PRIO_REGS; i++) begin
                r_prio[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_prio[i_cfg_index] <= i_cfg_data;
        end
    end

    // kernel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NT; i++) begin
                r_tstate[i] <= psched_pkg::ST_READY;
                r_link[i]   <= psched_pkg::NO_TASK;
            end
            for (int i = 0; i < NS; i++) begin
                r_count[i] <= psched_pkg::CNT_RESET;
                r_head[i]  <= psched_pkg::NO_TASK;
            end
            r_running <= psched_pkg::NO_TASK;
        end else if (i_cmd.exec) begin
            case (r_kind)
                psched_pkg::KIND_SCHEDULE: begin
                    if (pick_idx != psched_pkg::NO_TASK) begin
                        if (!has_runner) begin
                            r_tstate[pick_idx[TW-1:0]] <= psched_pkg::ST_EXEC;
                            r_running <= pick_idx;
                        end else if (pick_prio < run_prio) begin
                            r_tstate[run_idx]          <= psched_pkg::ST_READY;
                            r_tstate[pick_idx[TW-1:0]] <= psched_pkg::ST_EXEC;
                            r_running <= pick_idx;
                        end
                    end
                end
                psched_pkg::KIND_WAIT: begin
                    if (has_runner && sem_ok) begin
                        r_count[sem_idx] <= cnt_dec;
                        if (cnt_dec < 0) begin
                            r_tstate[run_idx] <= psched_pkg::ST_WAIT;
                            r_link[run_idx]   <= psched_pkg::NO_TASK;
                            r_running         <= psched_pkg::NO_TASK;
                            if (!head_valid) begin
                                r_head[sem_idx] <= r_running;
                            end
                        end
                    end
                end
                psched_pkg::KIND_SIGNAL: begin
                    if (sem_ok) begin
                        r_count[sem_idx] <= cnt_inc;
                        if (cnt_inc <= 0 && head_valid) begin
                            r_head[sem_idx]       <= r_link[head[TW-1:0]];
                            r_link[head[TW-1:0]]   <= psched_pkg::NO_TASK;
                            r_tstate[head[TW-1:0]] <= psched_pkg::ST_READY;
                        end
                    end
                end
                default: begin
                    if (has_runner) begin
                        r_tstate[run_idx] <= psched_pkg::ST_SLICED;
                        r_running         <= psched_pkg::NO_TASK;
                    end
                end
            endcase
        end else if (i_cmd.walk_step && walk_done) begin
            r_link[walk_idx] <= r_waiter;
        end
    end

    // per-request working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_req.kind;
            r_sem      <= i_req.sem_index;
            r_scan_t   <= '0;
            r_rdy_prio <= psched_pkg::PRIO_LIMIT;
            r_rdy_idx  <= psched_pkg::NO_TASK;
            r_sld_prio <= psched_pkg::PRIO_LIMIT;
            r_sld_idx  <= psched_pkg::NO_TASK;
            r_blocked  <= 1'b0;
            r_woken_v  <= 1'b0;
            r_woken_t  <= '0;
            r_err      <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            r_scan_t <= r_scan_t + TW'(1);
            if (r_tstate[r_scan_t] == psched_pkg::ST_READY && scan_prio < r_rdy_prio) begin
                r_rdy_prio <= scan_prio;
                r_rdy_idx  <= LW'(r_scan_t);
            end
            if (r_tstate[r_scan_t] == psched_pkg::ST_SLICED && scan_prio < r_sld_prio) begin
                r_sld_prio <= scan_prio;
                r_sld_idx  <= LW'(r_scan_t);
            end
        end
        if (i_cmd.exec) begin
            r_waiter <= r_running;
            r_walk_t <= head;
            r_steps  <= '0;
            case (r_kind)
                psched_pkg::KIND_WAIT: begin
                    r_err     <= !has_runner;
                    r_blocked <= wait_blocks;
                end
                psched_pkg::KIND_SIGNAL: begin
                    if (sem_ok && cnt_inc <= 0 && head_valid) begin
                        r_woken_v <= 1'b1;
                        r_woken_t <= head;
                    end
                end
                psched_pkg::KIND_SLICE_END: begin
                    r_err <= !has_runner;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.walk_step && !walk_done) begin
            r_walk_t <= walk_link;
            r_steps  <= r_steps + psched_pkg::STEP_W'(1);
        end
        if (i_cmd.result_load) begin
            r_res.running_valid   <= has_runner;
            r_res.running_task    <= has_runner ? r_running[psched_pkg::TASK_W-1:0] : '0;
            r_res.caller_blocked  <= r_blocked;
            r_res.woken_valid     <= r_woken_v;
            r_res.woken_task      <= r_woken_t[psched_pkg::TASK_W-1:0];
            r_res.no_runner_error <= r_err;
        end
    end

    assign o_res = r_res;

endmodule

// File: rtl/core/priority_scheduler_semaphores.sv
// priority_scheduler_semaphores: pre-emptive priority scheduler with counting semaphores
// depends on psched_pkg; instantiates psched_ctrl and psched_dp
//
// request channel: i_req_valid / o_req_stall carry one kernel event (schedule, wait,
// signal, time slice end) in i_req. response channel: o_res_valid / i_res_stall carry
// exactly one t_res per request: the running task after the event, whether a wait
// blocked the caller, which task a signal woke, and whether a wait or slice end had
// no runner. priorities are written through i_cfg_we / i_cfg_index / i_cfg_data;
// the user must do so only while idle, which the block itself does not enforce. one
// request is processed at a time. a schedule scans the task table one task per cycle;
// a blocking wait on a non-empty queue also walks the queue, which holds at most
// NUM_TASKS - 1 tasks, to its tail. the next request is accepted in the cycle after
// a response is loaded, even while that response is still stalled; a stalled
// response holds the block in its final state until taken. reset leaves all tasks
// ready, no runner, semaphore counts at one, empty queues and all priorities zero.

module priority_scheduler_semaphores (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    output logic                                o_req_stall,
    input  psched_pkg::t_req                    i_req,
    output logic                                o_res_valid,
    input  logic                                i_res_stall,
    output psched_pkg::t_res                    o_res,
    input  logic                                i_cfg_we,
    input  logic [psched_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [psched_pkg::PRIO_W-1:0]       i_cfg_data
);

    psched_pkg::t_cmd cmd;
    psched_pkg::t_sts sts;

    psched_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_kind  (i_req.kind),
        .i_res_stall (i_res_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_req_stall (o_req_stall),
        .o_res_valid (o_res_valid)
    );

    psched_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (sts),
        .o_res       (o_res)
    );

    a_blocked_no_runner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.caller_blocked |-> !o_res.running_valid)
        else $error("blocked caller still reported as running");

    a_error_no_runner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.no_runner_error |-> !o_res.running_valid && !o_res.woken_valid)
        else $error("no-runner error with a runner or a woken task");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> o_req_stall)
        else $error("request accepted while previous one still in progress");

endmodule

// File: verif/tb_priority_scheduler_semaphores.sv
// tb_priority_scheduler_semaphores: self-checking bench for the priority scheduler
// sends kernel event requests, predicts each response with a scheduler model of its own
// and checks every response field; depends on psched_pkg and priority_scheduler_semaphores

module tb_priority_scheduler_semaphores;
    timeunit 1ns;
    timeprecision 1ps;

    import psched_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SHOWN_ERRORS  = 10;
    localparam int HOLD_OFF_LEN  = 400;

    localparam int STALL_NONE    = 0;
    localparam int STALL_RANDOM  = 1;
    localparam int STALL_PATTERN = 2;
    localparam int STALL_HEAVY   = 3;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    t_req                 req       = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    t_res                 res;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PRIO_W-1:0]    cfg_data  = '0;

    // scheduler model state
    logic [PRIO_W-1:0]       prio        [NUM_PRIO_REGS];
    logic [1:0]              tstate      [NUM_TASKS];
    logic [LINK_W-1:0]       next_waiter [NUM_TASKS];
    logic signed [CNT_W-1:0] sem_cnt     [NUM_SEMS];
    logic [LINK_W-1:0]       queue_head  [NUM_SEMS];
    logic [LINK_W-1:0]       runner;

    t_res        pending_outcomes [$];
    int          outcome_errors = 0;
    int          idle_cycles    = 0;
    int          stall_mode     = STALL_NONE;
    int          hold_left      = 0;
    int unsigned pattern_cnt    = 0;

    priority_scheduler_semaphores DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_stall (res_stall),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_req make_ev(input logic [1:0] kind, input logic sem);
        t_req ev;
        ev.kind      = kind;
        ev.sem_index = sem;
        return ev;
    endfunction

    function automatic logic [LINK_W-1:0] best_task(input logic [1:0] st);
        logic [LINK_W-1:0] best;
        logic [PRIO_W-1:0] bound;
        best  = NO_TASK;
        bound = PRIO_LIMIT;
        for (int t = 0; t < NUM_TASKS; t++) begin
            if (tstate[t] == st && prio[t] < bound) begin
                bound = prio[t];
                best  = LINK_W'(t);
            end
        end
        return best;
    endfunction

    function automatic t_res kernel_event_outcome(input t_req ev);
        t_res              out;
        logic [LINK_W-1:0] pick;
        logic [LINK_W-1:0] walk;
        logic [LINK_W-1:0] woke;
        logic              had_runner;
        int                s;
        out        = '0;
        had_runner = runner < NUM_TASKS;
        s          = int'(ev.sem_index);
        case (ev.kind)
            KIND_SCHEDULE: begin
                pick = best_task(ST_READY);
                if (pick == NO_TASK)
                    pick = best_task(ST_SLICED);
                if (pick != NO_TASK) begin
                    if (!had_runner) begin
                        tstate[pick] = ST_EXEC;
                        runner       = pick;
                    end else if (prio[pick] < prio[runner]) begin
                        tstate[runner] = ST_READY;
                        tstate[pick]   = ST_EXEC;
                        runner         = pick;
                    end
                end
            end
            KIND_WAIT: begin
                if (!had_runner) begin
                    out.no_runner_error = 1'b1;
                end else if (s < NUM_SEMS) begin
                    if (sem_cnt[s] > CNT_MIN)
                        sem_cnt[s] = sem_cnt[s] - 4'sd1;
                    if (sem_cnt[s] < 0) begin
                        tstate[runner]      = ST_WAIT;
                        next_waiter[runner] = NO_TASK;
                        walk                = queue_head[s];
                        if (walk >= NUM_TASKS) begin
                            queue_head[s] = runner;
                        end else begin
                            // walk to the tail of the wait queue
                            for (int n = 0; n < NUM_TASKS; n++) begin
                                if (next_waiter[walk] < NUM_TASKS)
                                    walk = next_waiter[walk];
                            end
                            next_waiter[walk] = runner;
                        end
                        runner             = NO_TASK;
                        out.caller_blocked = 1'b1;
                    end
                end
            end
            KIND_SIGNAL: begin
                if (s < NUM_SEMS) begin
                    if (sem_cnt[s] < CNT_MAX)
                        sem_cnt[s] = sem_cnt[s] + 4'sd1;
                    if (sem_cnt[s] <= 0) begin
                        woke = queue_head[s];
                        if (woke < NUM_TASKS) begin
                            queue_head[s]     = next_waiter[woke];
                            next_waiter[woke] = NO_TASK;
                            tstate[woke]      = ST_READY;
                            out.woken_valid   = 1'b1;
                            out.woken_task    = woke[TASK_W-1:0];
                        end
                    end
                end
            end
            default: begin
                if (!had_runner) begin
                    out.no_runner_error = 1'b1;
                end else begin
                    tstate[runner] = ST_SLICED;
                    runner         = NO_TASK;
                end
            end
        endcase
        out.running_valid = runner < NUM_TASKS;
        out.running_task  = out.running_valid ? runner[TASK_W-1:0] : '0;
        return out;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(input t_req ev);
        req_valid = 1'b1;
        req       = ev;
        do @(posedge i_clk); while (req_stall);
        pending_outcomes.push_back(kernel_event_outcome(ev));
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_valid = 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge i_clk);
        repeat (NUM_TASKS + 6) @(negedge i_clk);
    endtask

    task automatic set_priorities(input logic [PRIO_W-1:0] p0, p1, p2, p3);
        logic [PRIO_W-1:0] vals [NUM_PRIO_REGS];
        vals = '{p0, p1, p2, p3};
        drain();
        for (int i = 0; i < NUM_PRIO_REGS; i++) begin
            cfg_we    = 1'b1;
            cfg_index = CFG_IDX_W'(i);
            cfg_data  = vals[i];
            prio[i]   = vals[i];
            @(negedge i_clk);
        end
        cfg_we = 1'b0;
    endtask

    task automatic run_traffic(input int count, input int max_gap);
        int   sent;
        int   burst;
        int   gap;
        int   roll;
        t_req ev;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < count; b++) begin
                roll = $urandom_range(0, 99);
                if (roll < 35)
                    ev.kind = KIND_SCHEDULE;
                else if (roll < 60)
                    ev.kind = KIND_WAIT;
                else if (roll < 85)
                    ev.kind = KIND_SIGNAL;
                else
                    ev.kind = KIND_SLICE_END;
                ev.sem_index = 1'($urandom_range(0, 1));
                send_req(ev);
                sent++;
            end
            gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
            if (gap > 0) begin
                req_valid     = 1'b0;
                req.kind      = 2'($urandom_range(0, 3));
                req.sem_index = 1'($urandom_range(0, 1));
                repeat (gap) @(negedge i_clk);
            end
        end
        req_valid = 1'b0;
    endtask

    task automatic test_no_runner_events();
        send_req(make_ev(KIND_WAIT, 1'b0));
        send_req(make_ev(KIND_SLICE_END, 1'b1));
        send_req(make_ev(KIND_SIGNAL, 1'b1));
        send_req(make_ev(KIND_SCHEDULE, 1'b0));
        send_req(make_ev(KIND_SCHEDULE, 1'b1));
    endtask

    task automatic test_preemption_and_queueing();
        set_priorities(7'd50, 7'd10, 7'd127, 7'd99);
        send_req(make_ev(KIND_SCHEDULE, 1'b0));
        send_req(make_ev(KIND_WAIT, 1'b0));
        send_req(make_ev(KIND_WAIT, 1'b0));
        send_req(make_ev(KIND_SCHEDULE, 1'b1));
        send_req(make_ev(KIND_WAIT, 1'b0));
        // nothing eligible left to pick
        send_req(make_ev(KIND_SCHEDULE, 1'b0));
        send_req(make_ev(KIND_SIGNAL, 1'b0));
        send_req(make_ev(KIND_SIGNAL, 1'b0));
        send_req(make_ev(KIND_SIGNAL, 1'b0));
        send_req(make_ev(KIND_SCHEDULE, 1'b0));
        send_req(make_ev(KIND_SLICE_END, 1'b0));
        send_req(make_ev(KIND_SCHEDULE, 1'b0));
        send_req(make_ev(KIND_SLICE_END, 1'b1));
        send_req(make_ev(KIND_SCHEDULE, 1'b1));
    endtask

    task automatic test_counter_saturation();
        repeat (6) send_req(make_ev(KIND_SIGNAL, 1'b1));
    endtask

    task automatic test_random_mixed_priorities();
        stall_mode = STALL_RANDOM;
        repeat (3) begin
            set_priorities(PRIO_W'($urandom_range(0, 99)), PRIO_W'($urandom_range(0, 99)),
                           PRIO_W'($urandom_range(0, 99)), PRIO_W'($urandom_range(0, 127)));
            run_traffic(300, 6);
        end
    endtask

    task automatic test_unschedulable_priorities();
        stall_mode = STALL_PATTERN;
        set_priorities(7'd100, 7'd127, PRIO_W'($urandom_range(100, 127)), 7'd0);
        run_traffic(100, 4);
    endtask

    task automatic test_priority_boundaries();
        stall_mode = STALL_PATTERN;
        set_priorities(7'd99, 7'd100, 7'd0, 7'd127);
        run_traffic(150, 3);
        set_priorities(7'd0, 7'd99, 7'd99, 7'd100);
        run_traffic(150, 3);
    endtask

    task automatic test_response_hold_off();
        stall_mode = STALL_NONE;
        set_priorities(7'd20, 7'd5, 7'd60, 7'd1);
        hold_left = HOLD_OFF_LEN;
        run_traffic(60, 0);
    endtask

    task automatic test_pause_until_empty();
        stall_mode = STALL_HEAVY;
        set_priorities(PRIO_W'($urandom_range(0, 99)), PRIO_W'($urandom_range(0, 99)),
                       PRIO_W'($urandom_range(0, 99)), PRIO_W'($urandom_range(0, 99)));
        repeat (5) begin
            run_traffic(30, 2);
            while (pending_outcomes.size() != 0)
                @(negedge i_clk);
        end
    endtask

    task automatic test_random_equal_priorities();
        logic [PRIO_W-1:0] level;
        level      = PRIO_W'($urandom_range(0, 99));
        stall_mode = STALL_NONE;
        set_priorities(level, level, level, level);
        run_traffic(100, 0);
        stall_mode = STALL_RANDOM;
        run_traffic(100, 7);
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        pattern_cnt = pattern_cnt + 1;
        if (hold_left > 0) begin
            res_stall = 1'b1;
            hold_left = hold_left - 1;
        end else begin
            case (stall_mode)
                STALL_NONE:    res_stall = 1'b0;
                STALL_RANDOM:  res_stall = ($urandom_range(0, 2) == 0);
                STALL_PATTERN: res_stall = (pattern_cnt % 7) < 3;
                default:       res_stall = ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        logic bad;
        if (i_rst_n && res_valid && !res_stall) begin
            if (pending_outcomes.size() == 0) begin
                outcome_errors++;
                if (outcome_errors <= SHOWN_ERRORS)
                    $display("response with no request outstanding: %h", res);
            end else begin
                want = pending_outcomes.pop_front();
                bad  = (res.running_valid !== want.running_valid)
                    || (res.running_task !== want.running_task)
                    || (res.caller_blocked !== want.caller_blocked)
                    || (res.woken_valid !== want.woken_valid)
                    || (res.woken_task !== want.woken_task)
                    || (res.no_runner_error !== want.no_runner_error);
                if (bad) begin
                    outcome_errors++;
                    if (outcome_errors <= SHOWN_ERRORS)
                        $display({"response mismatch: expected run %b/%0d blk %b wake %b/%0d ",
                                  "err %b, got run %b/%0d blk %b wake %b/%0d err %b"},
                                 want.running_valid, want.running_task, want.caller_blocked,
                                 want.woken_valid, want.woken_task, want.no_runner_error,
                                 res.running_valid, res.running_task, res.caller_blocked,
                                 res.woken_valid, res.woken_task, res.no_runner_error);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_PRIO_REGS; i++)
            prio[i] = '0;
        for (int t = 0; t < NUM_TASKS; t++) begin
            tstate[t]      = ST_READY;
            next_waiter[t] = NO_TASK;
        end
        for (int s = 0; s < NUM_SEMS; s++) begin
            sem_cnt[s]    = CNT_RESET;
            queue_head[s] = NO_TASK;
        end
        runner = NO_TASK;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_no_runner_events();
        test_preemption_and_queueing();
        test_counter_saturation();
        test_random_mixed_priorities();
        test_unschedulable_priorities();
        test_priority_boundaries();
        test_response_hold_off();
        test_pause_until_empty();
        test_random_equal_priorities();

        drain();
        if (outcome_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
